/* rtl/core/imb_pkg.sv */
// ----------------------------------------------------------------------------
// imb_pkg
// shared types, constants and helpers of the imu bias calibrator
// ----------------------------------------------------------------------------
package imb_pkg;

    localparam int AXES     = 6;
    localparam int AXIS_IW  = $clog2(AXES);
    localparam int DATA_W   = 32;
    localparam int STAMP_W  = 64;
    localparam int CFG_W    = 16;

    // product of a q16.16 sample and a scale constant
    localparam int K_W      = 29;
    localparam int PROD_W   = DATA_W + K_W;
    // converted value at full width
    localparam int CONV_W   = 37;
    localparam int SAT_W    = 40;

    localparam int ACC_SHIFT  = 24;
    localparam int GYRO_SHIFT = 32;

    localparam int AXIS_AZ = 2;
    localparam int AXIS_GX = 3;

    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = 16'd1000;
    localparam int GRAV_Q16 = 642689;

    // scale per axis: gravity q8.24 for accel, pi/180 q0.32 for gyro,
    // negative on the mirrored x and z axes
    localparam logic signed [K_W-1:0] AXIS_K [AXES] = '{
        -29'sd164528285, 29'sd164528285, -29'sd164528285,
        -29'sd74961321,  29'sd74961321,  -29'sd74961321
    };

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_START  = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [AXES-1:0][CONV_W-1:0]   conv;
        logic [STAMP_W-1:0]            stamp;
    } imb_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } imb_state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1))
            r = v[DATA_W-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

/* rtl/core/imb_front.sv */
// ----------------------------------------------------------------------------
// imb_front
// accepts items, scales the six axes to si units and pushes them queued
// ----------------------------------------------------------------------------
module imb_front (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       in_func,
    input  logic [imb_pkg::AXES-1:0][imb_pkg::DATA_W-1:0] in_raw,
    input  logic [imb_pkg::STAMP_W-1:0]                in_stamp,
    input  logic                                       q_full,
    output logic                                       push,
    output imb_pkg::imb_item_t                         push_item
);
    import imb_pkg::*;

    localparam logic signed [PROD_W-1:0] ACC_HALF  = PROD_W'(1) << (ACC_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] GYRO_HALF = PROD_W'(1) << (GYRO_SHIFT - 1);

    logic                        s1_valid_reg;
    logic                        s1_func_reg;
    logic signed [DATA_W-1:0]    s1_raw_reg [AXES];
    logic [STAMP_W-1:0]          s1_stamp_reg;

    logic                        s2_valid_reg;
    logic                        s2_func_reg;
    logic signed [PROD_W-1:0]    s2_prod_reg [AXES];
    logic [STAMP_W-1:0]          s2_stamp_reg;

    logic                        s1_load;
    logic                        s2_load;
    logic signed [PROD_W-1:0]    rnd [AXES];

    assign push     = s2_valid_reg && !q_full;
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || push);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_load || (s1_valid_reg && !s2_load);
            s2_valid_reg <= s2_load || (s2_valid_reg && !push);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_func_reg  <= in_func;
            s1_stamp_reg <= in_stamp;
            for (int i = 0; i < AXES; i++)
                s1_raw_reg[i] <= $signed(in_raw[i]);
        end
        if (s2_load)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_stamp_reg <= s1_stamp_reg;
            for (int i = 0; i < AXES; i++)
                s2_prod_reg[i] <= s1_raw_reg[i] * AXIS_K[i];
        end
    end

    // round half up, back to q16.16
    always_comb
    begin
        push_item.func  = s2_func_reg;
        push_item.stamp = s2_stamp_reg;
        for (int i = 0; i < AXES; i++)
        begin
            if (i < AXIS_GX)
            begin
                rnd[i]            = s2_prod_reg[i] + ACC_HALF;
                push_item.conv[i] = CONV_W'(rnd[i] >>> ACC_SHIFT);
            end
            else
            begin
                rnd[i]            = s2_prod_reg[i] + GYRO_HALF;
                push_item.conv[i] = CONV_W'(rnd[i] >>> GYRO_SHIFT);
            end
        end
    end

endmodule

/* rtl/core/imb_queue.sv */
// ----------------------------------------------------------------------------
// imb_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module imb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  imb_pkg::imb_item_t push_item,
    output logic               full,
    input  logic               pop,
    output imb_pkg::imb_item_t head,
    output logic               empty
);
    import imb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    imb_item_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : PTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)
                count_reg <= CNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/core/imb_div.sv */
// ----------------------------------------------------------------------------
// imb_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module imb_div #(
    parameter int SUM_W = 48,
    parameter int DIV_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg - 1'b1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? DIV_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DIV_W-1:0];
        end
    end

endmodule

/* rtl/core/imb_back.sv */
// ----------------------------------------------------------------------------
// imb_back
// calibration control, bias averaging and bias subtraction with output stage
// ----------------------------------------------------------------------------
module imb_back #(
    parameter int COUNT_BITS = imb_pkg::COUNT_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_wr,
    input  logic [imb_pkg::CFG_W-1:0]                     cfg_data,
    input  imb_pkg::imb_item_t                            head,
    input  logic                                          q_empty,
    output logic                                          pop,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [imb_pkg::AXES-1:0][imb_pkg::DATA_W-1:0] out_data,
    output logic [imb_pkg::STAMP_W-1:0]                   out_stamp,
    output logic                                          out_calibrating,
    output logic                                          out_updated
);
    import imb_pkg::*;

    localparam int SUM_W  = DATA_W + COUNT_BITS;
    localparam int CMP_W  = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int BIAS_W = DATA_W + 2;

    imb_state_t                 state_reg, state_next;
    logic                       calib_reg, calib_next;
    logic [COUNT_BITS-1:0]      taken_reg;
    logic [CFG_W-1:0]           sample_count_reg;
    logic signed [SUM_W-1:0]    sum_reg [AXES];
    logic signed [DATA_W-1:0]   bias_reg [AXES];
    logic [AXIS_IW-1:0]         axis_reg, axis_next;

    logic                       out_valid_reg;
    logic [AXES-1:0][DATA_W-1:0] out_data_reg;
    logic [STAMP_W-1:0]         out_stamp_reg;
    logic                       out_cal_reg;
    logic                       out_upd_reg;

    logic                       out_free;
    logic                       can_acc;
    logic                       out_load;
    logic                       out_cal;
    logic                       out_upd;
    logic                       acc_en;
    logic                       clear_en;
    logic                       div_start;
    logic                       bias_wr;

    logic signed [SUM_W-1:0]    sum_sel;
    logic [SUM_W-1:0]           sum_mag;
    logic [SUM_W-1:0]           dividend;
    logic                       div_done;
    logic [SUM_W-1:0]           quotient;
    logic signed [BIAS_W-1:0]   q_mag;
    logic signed [BIAS_W-1:0]   bias_raw;
    logic signed [BIAS_W-1:0]   bias_adj;
    logic signed [DATA_W-1:0]   bias_new;
    logic [AXES-1:0][DATA_W-1:0] corr;

    assign out_free = !out_valid_reg || out_ready;
    assign can_acc  = (CMP_W'(taken_reg) < CMP_W'(sample_count_reg)) && !(&taken_reg);

    // divider operands: magnitude of the sum plus half the count
    assign sum_sel  = sum_reg[axis_reg];
    assign sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign dividend = SUM_W'(sum_mag + SUM_W'(taken_reg >> 1));

    imb_div #(
        .SUM_W (SUM_W),
        .DIV_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (taken_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // signed mean, gravity removed from z accel
    always_comb
    begin
        q_mag    = BIAS_W'({1'b0, quotient[DATA_W:0]});
        bias_raw = sum_sel[SUM_W-1] ? -q_mag : q_mag;
        bias_adj = bias_raw;
        if (axis_reg == AXIS_IW'(AXIS_AZ))
        begin
            if (bias_raw > 0)
                bias_adj = bias_raw - BIAS_W'(GRAV_Q16);
            else if (bias_raw < 0)
                bias_adj = bias_raw + BIAS_W'(GRAV_Q16);
        end
        bias_new = sat32(SAT_W'(bias_adj));
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            corr[i] = sat32(SAT_W'($signed(head.conv[i])) - SAT_W'(bias_reg[i]));
    end

    always_comb
    begin
        state_next = state_reg;
        calib_next = calib_reg;
        axis_next  = axis_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_cal    = 1'b0;
        out_upd    = 1'b0;
        acc_en     = 1'b0;
        clear_en   = 1'b0;
        div_start  = 1'b0;
        bias_wr    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.func == FUNC_START)
                    begin
                        pop        = 1'b1;
                        clear_en   = 1'b1;
                        calib_next = 1'b1;
                    end
                    else if (out_free)
                    begin
                        if (calib_reg && can_acc)
                        begin
                            acc_en   = 1'b1;
                            pop      = 1'b1;
                            out_load = 1'b1;
                            out_cal  = 1'b1;
                        end
                        else if (calib_reg && (taken_reg != '0))
                        begin
                            calib_next = 1'b0;
                            axis_next  = '0;
                            state_next = ST_START;
                        end
                        else
                        begin
                            calib_next = 1'b0;
                            pop        = 1'b1;
                            out_load   = 1'b1;
                        end
                    end
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    bias_wr = 1'b1;
                    if (axis_reg == AXIS_IW'(AXES - 1))
                        state_next = ST_OUT;
                    else
                    begin
                        axis_next  = AXIS_IW'(axis_reg + 1'b1);
                        state_next = ST_START;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    pop        = 1'b1;
                    out_load   = 1'b1;
                    out_upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            calib_reg        <= 1'b0;
            axis_reg         <= '0;
            taken_reg        <= '0;
            sample_count_reg <= SAMPLE_COUNT_RST;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            calib_reg     <= calib_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (cfg_wr)
                sample_count_reg <= cfg_data;
            if (clear_en)
            begin
                taken_reg <= '0;
                for (int i = 0; i < AXES; i++)
                    sum_reg[i] <= '0;
            end
            else if (acc_en)
            begin
                taken_reg <= COUNT_BITS'(taken_reg + 1'b1);
                for (int i = 0; i < AXES; i++)
                    sum_reg[i] <= sum_reg[i]
                        + SUM_W'(sat32(SAT_W'($signed(head.conv[i]))));
            end
            if (bias_wr)
                bias_reg[axis_reg] <= bias_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= corr;
            out_stamp_reg <= head.stamp;
            out_cal_reg   <= out_cal;
            out_upd_reg   <= out_upd;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_stamp       = out_stamp_reg;
    assign out_calibrating = out_cal_reg;
    assign out_updated     = out_upd_reg;

endmodule

/* rtl/core/imu_bias_calibrator_top.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibrator_top
// six-axis imu correction with static bias calibration
// ----------------------------------------------------------------------------
// A transfer on the slave side enters a two-stage front that scales the
// six axes (one constant multiplier per axis, then a rounding add) and drops
// the item into a two-entry queue; the back takes one item per cycle from the
// queue into the output register while the output is not stalled and no
// calibration is ending, so the block then sustains one item per clock. An
// item passes the two front registers, the queue and the output register
// before its output transfer. The sample that ends a calibration holds the
// back while a shared restoring divider works out the six means one after
// the other; the front keeps taking items until the queue and the front
// registers are full. A start command produces no output. The bias resets to
// zero, no clearing pass is needed after reset, and cfg_ready is always high.
module imu_bias_calibrator_top #(
    parameter int COUNT_BITS = imb_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, stamp_us
    input  logic [255:0]                s_axis_tdata,
    // func
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y,
    // out_gyro_z, out_stamp_us
    output logic [255:0]                m_axis_tdata,
    // calibrating, bias_updated
    output logic [1:0]                  m_axis_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [imb_pkg::CFG_W-1:0]   cfg_data
);
    import imb_pkg::*;

    localparam int AXIS_BITS = AXES * DATA_W;

    logic                         push;
    imb_item_t                    push_item;
    logic                         q_full;
    logic                         q_empty;
    logic                         pop;
    imb_item_t                    head;
    logic [AXES-1:0][DATA_W-1:0]  in_raw;
    logic [AXES-1:0][DATA_W-1:0]  out_data;
    logic [STAMP_W-1:0]           out_stamp;
    logic                         out_cal;
    logic                         out_upd;

    assign cfg_ready = 1'b1;
    assign in_raw    = s_axis_tdata[AXIS_BITS-1:0];

    imb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser[0]),
        .in_raw    (in_raw),
        .in_stamp  (s_axis_tdata[AXIS_BITS +: STAMP_W]),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    imb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    imb_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .head            (head),
        .q_empty         (q_empty),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (out_data),
        .out_stamp       (out_stamp),
        .out_calibrating (out_cal),
        .out_updated     (out_upd)
    );

    assign m_axis_tdata = {out_stamp, out_data};
    assign m_axis_tuser = {out_upd, out_cal};

endmodule

/* sim/imb_result_checker.sv */
// ----------------------------------------------------------------------------
// imb_result_checker
// watches the sample, result and sample_count channels of the imu bias
// calibrator, predicts every corrected sample and compares it field by field
// ----------------------------------------------------------------------------
module imb_result_checker #(
    parameter int COUNT_BITS = imb_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [255:0]                s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [255:0]                m_tdata,
    input  logic [1:0]                  m_tuser,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [imb_pkg::CFG_W-1:0]   cfg_data,
    output int                          error_count,
    output int                          pending_results,
    output int                          results_checked,
    output int                          bias_updates
);
    import imb_pkg::*;

    localparam longint GRAV_Q24    = 64'sd164528285;
    localparam longint DEG2RAD_Q32 = 64'sd74961321;
    localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [AXES-1:0][DATA_W-1:0]    axis;
        logic [STAMP_W-1:0]             stamp;
        logic                           calibrating;
        logic                           bias_updated;
    } imu_result_t;

    imu_result_t    expected_outputs[$];
    bit             collecting;
    int unsigned    samples_in;
    int unsigned    target_count;
    longint         axis_acc[AXES];
    longint         axis_offset[AXES];

    function automatic longint clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // g to m/s^2 and deg/s to rad/s, x and z mirrored, kept at full width
    function automatic longint convert_axis(input int idx, input logic [DATA_W-1:0] raw);
        longint v;
        v = $signed(raw);
        if (idx == 0 || idx == 2 || idx == 3 || idx == 5)
            v = -v;
        if (idx < AXIS_GX)
            return (v * GRAV_Q24 + (64'sd1 <<< 23)) >>> 24;
        return (v * DEG2RAD_Q32 + (64'sd1 <<< 31)) >>> 32;
    endfunction

    // ties away from zero
    function automatic longint rounded_mean(input longint sum, input int unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (sum < 0) ? -sum : sum;
        q = (mag + n / 2) / n;
        return (sum < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        if (error_count < PRINT_CAP)
            $display("mismatch in %s at result %0d: expected %h, got %h",
                     field, results_checked, want, got);
        error_count++;
    endtask

    task automatic apply_imu_item(input logic func, input logic [255:0] data);
        longint         conv[AXES];
        imu_result_t    r;
        bit             updated;
        if (func == FUNC_START)
        begin
            collecting = 1'b1;
            samples_in = 0;
            foreach (axis_acc[i])
                axis_acc[i] = 0;
            return;
        end
        updated = 1'b0;
        for (int i = 0; i < AXES; i++)
            conv[i] = convert_axis(i, data[i*DATA_W +: DATA_W]);
        if (collecting)
        begin
            if (samples_in < target_count && samples_in < COUNT_MAX)
            begin
                for (int i = 0; i < AXES; i++)
                    axis_acc[i] += clamp_q16(conv[i]);
                samples_in++;
            end
            else
            begin
                collecting = 1'b0;
                if (samples_in != 0)
                begin
                    for (int i = 0; i < AXES; i++)
                        axis_offset[i] = rounded_mean(axis_acc[i], samples_in);
                    // remove gravity from the z-accel bias
                    if (axis_offset[AXIS_AZ] > 0)
                        axis_offset[AXIS_AZ] = clamp_q16(axis_offset[AXIS_AZ] - GRAV_Q16);
                    else if (axis_offset[AXIS_AZ] < 0)
                        axis_offset[AXIS_AZ] = clamp_q16(axis_offset[AXIS_AZ] + GRAV_Q16);
                    updated = 1'b1;
                end
            end
        end
        for (int i = 0; i < AXES; i++)
            r.axis[i] = DATA_W'(clamp_q16(conv[i] - axis_offset[i]));
        r.stamp        = data[255 -: STAMP_W];
        r.calibrating  = collecting;
        r.bias_updated = updated;
        expected_outputs.insert(expected_outputs.size(), r);
    endtask

    task automatic check_result(input logic [255:0] data, input logic [1:0] user);
        imu_result_t want;
        if (expected_outputs.size() == 0)
        begin
            report_mismatch("unexpected result stamp", '0, data[255 -: STAMP_W]);
            return;
        end
        want = expected_outputs.pop_front();
        for (int i = 0; i < AXES; i++)
            if (data[i*DATA_W +: DATA_W] !== want.axis[i])
                report_mismatch($sformatf("axis %0d", i), 64'(want.axis[i]),
                                64'(data[i*DATA_W +: DATA_W]));
        if (data[255 -: STAMP_W] !== want.stamp)
            report_mismatch("stamp", want.stamp, data[255 -: STAMP_W]);
        if (user[0] !== want.calibrating)
            report_mismatch("calibrating", 64'(want.calibrating), 64'(user[0]));
        if (user[1] !== want.bias_updated)
            report_mismatch("bias_updated", 64'(want.bias_updated), 64'(user[1]));
        if (want.bias_updated)
            bias_updates++;
        results_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_outputs.delete();
            collecting      = 1'b0;
            samples_in      = 0;
            target_count    = SAMPLE_COUNT_RST;
            foreach (axis_acc[i])
            begin
                axis_acc[i]    = 0;
                axis_offset[i] = 0;
            end
            error_count     = 0;
            pending_results = 0;
            results_checked = 0;
            bias_updates    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready)
                target_count = cfg_data;
            if (s_tvalid && s_tready)
                apply_imu_item(s_tuser[0], s_tdata);
            pending_results = expected_outputs.size();
        end
    end

endmodule

/* sim/imu_bias_calibrator_top_tb.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibrator_top_tb
// drives samples, start commands and sample_count writes into the calibrator
// with random gaps and back-pressure; a checker beside the block predicts and
// compares every corrected sample
// ----------------------------------------------------------------------------
module imu_bias_calibrator_top_tb;
    import imb_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int LIMIT_CYCLES  = 4000000;

    logic               clk;
    logic               rst_n           = 1'b0;
    logic               s_axis_tvalid   = 1'b0;
    logic               s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, stamp_us
    logic [255:0]       s_axis_tdata    = '0;
    // func
    logic [0:0]         s_axis_tuser    = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready   = 1'b0;
    // out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y,
    // out_gyro_z, out_stamp_us
    logic [255:0]       m_axis_tdata;
    // calibrating, bias_updated
    logic [1:0]         m_axis_tuser;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data        = '0;

    int error_count;
    int pending_results;
    int results_checked;
    int bias_updates;

    int          cycle_count   = 0;
    int          items_sent    = 0;
    int          starts_sent   = 0;
    int          cfg_writes    = 0;
    int unsigned current_count = SAMPLE_COUNT_RST;
    bit          send_burst    = 1'b0;
    bit          recv_burst    = 1'b0;

    int unsigned phase_counts[8] = '{1000, 1, 2, 5, 9, 17, 33, 64};

    imu_bias_calibrator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    imb_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .bias_updates    (bias_updates)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // log-uniform magnitudes so both realistic and saturating values show up
    function automatic logic [DATA_W-1:0] draw_axis();
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, DATA_W - 1);
    endfunction

    function automatic logic [STAMP_W-1:0] draw_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [AXES-1:0][DATA_W-1:0] draw_axes();
        logic [AXES-1:0][DATA_W-1:0] ax;
        for (int i = 0; i < AXES; i++)
            ax[i] = draw_axis();
        return ax;
    endfunction

    task automatic send_item(input logic func, input logic [AXES-1:0][DATA_W-1:0] ax,
                             input logic [STAMP_W-1:0] stamp);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, ax};
        s_axis_tuser  <= func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (func == FUNC_START)
            starts_sent++;
    endtask

    task automatic send_sample();
        send_item(FUNC_SAMPLE, draw_axes(), draw_stamp());
    endtask

    task automatic send_start();
        send_item(FUNC_START, draw_axes(), draw_stamp());
    endtask

    task automatic send_flat(input logic [DATA_W-1:0] v, input logic [STAMP_W-1:0] stamp);
        send_item(FUNC_SAMPLE, {AXES{v}}, stamp);
    endtask

    // hold off until every result is back and the divider has gone quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sample_count(input int unsigned value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        current_count = value;
        cfg_writes++;
    endtask

    // mostly complete calibrations, with stray samples and restarts mixed in
    task automatic run_calibrations(input int budget, input bit with_breaks);
        int done;
        int len;
        done = 0;
        while (done < budget)
        begin
            if (with_breaks && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                begin
                    send_sample();
                    done++;
                end
            send_start();
            done++;
            len = current_count + 1 + (with_breaks ? $urandom_range(0, 3) : 1);
            for (int i = 0; i < len; i++)
            begin
                if (with_breaks && $urandom_range(0, 59) == 0)
                    send_start();
                send_sample();
            end
            done += len;
        end
    endtask

    initial
    begin
        logic [AXES-1:0][DATA_W-1:0] ax;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes with no bias yet
        send_flat(32'h0000_0000, 64'h0);
        send_flat(32'h7fff_ffff, '1);
        send_flat(32'h8000_0000, draw_stamp());
        send_flat(32'hffff_ffff, draw_stamp());
        send_flat(32'h0000_0001, draw_stamp());
        send_flat(32'h0001_0000, draw_stamp());

        // restart while calibrating
        send_start();
        repeat (3) send_sample();
        send_start();
        repeat (5) send_sample();

        // count lowered below the samples already taken
        write_sample_count(3);
        repeat (2) send_sample();

        // empty calibration
        write_sample_count(0);
        send_start();
        repeat (2) send_sample();

        // zero mean on z-accel
        write_sample_count(1);
        send_start();
        ax = draw_axes();
        ax[AXIS_AZ] = '0;
        send_item(FUNC_SAMPLE, ax, draw_stamp());
        repeat (2) send_sample();

        foreach (phase_counts[i])
        begin
            write_sample_count(phase_counts[i]);
            run_calibrations((phase_counts[i] > 100) ? 1 : 60, 1'b1);
        end
        repeat (4)
        begin
            write_sample_count($urandom_range(1, 40));
            run_calibrations(60, 1'b1);
        end

        settle_block();
        $display("sent %0d items (%0d start commands) across %0d sample_count writes",
                 items_sent, starts_sent, cfg_writes);
        $display("checked %0d corrected samples including %0d bias updates",
                 results_checked, bias_updates);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* imu_bias_calibrator_top.f */
rtl/core/imb_pkg.sv
rtl/core/imb_front.sv
rtl/core/imb_queue.sv
rtl/core/imb_div.sv
rtl/core/imb_back.sv
rtl/core/imu_bias_calibrator_top.sv
sim/imb_result_checker.sv
sim/imu_bias_calibrator_top_tb.sv
